### hw/rtl/apbp_pkg.sv
package apbp_pkg;

  // tree size and address widths
  localparam int MAX_STEPS = 1024;
  localparam int ADDR_W    = $clog2(MAX_STEPS + 1);
  localparam int STEP_W    = 11;
  localparam int DATA_W    = 32;
  localparam int LAD_W     = 2 * DATA_W;
  localparam int CFG_IDX_W = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UP_FACTOR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_FACT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROB_UP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT   = 3'd4;

  // register reset values
  localparam logic [STEP_W-1:0] RST_STEP_COUNT = 11'd1000;
  localparam logic [DATA_W-1:0] RST_UP_FACTOR  = 32'h4000_0000;
  localparam logic [DATA_W-1:0] RST_DOWN_FACT  = 32'h4000_0000;
  localparam logic [DATA_W-1:0] RST_PROB_UP    = 32'h8000_0000;
  localparam logic [DATA_W-1:0] RST_DISCOUNT   = 32'hFFFF_FFFF;

  // one in Q2.30
  localparam logic [DATA_W-1:0] Q30_ONE = 32'h4000_0000;

  typedef struct packed {
    logic [STEP_W-1:0] step_count;
    logic [DATA_W-1:0] up_factor;
    logic [DATA_W-1:0] down_factor;
    logic [DATA_W-1:0] prob_up;
    logic [DATA_W-1:0] discount_factor;
  } apbp_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } apbp_status_t;

  // round a Q2.30 product to nearest, ties up, saturate to 32 bits
  function automatic logic [DATA_W-1:0] q30_round_sat(input logic [LAD_W-1:0] prod);
    logic [LAD_W:0] sum;
    sum = {1'b0, prod} + 65'(64'd1 << 29);
    if (sum[LAD_W:DATA_W+30] != '0) begin
      q30_round_sat = '1;
    end else begin
      q30_round_sat = sum[DATA_W+29:30];
    end
  endfunction

  // put payoff max(k - s, 0)
  function automatic logic [DATA_W-1:0] put_payoff(input logic [DATA_W-1:0] strike,
                                                   input logic [DATA_W-1:0] price);
    put_payoff = (strike > price) ? (strike - price) : '0;
  endfunction

endpackage

### hw/rtl/american_put_binomial_pricer.sv
// American put pricer on a Cox-Ross-Rubinstein binomial tree.
// Input channel: spot_price and strike_price (Q16.16) with in_valid/in_stall;
// an item is taken at a clock edge with in_valid high and in_stall low.
// Output channel: option_value (Q16.16) with out_valid/out_stall; one result
// per item, held steady while out_stall is high.
// Configuration: write cfg_index/cfg_data with cfg_we while the block is idle.
// Index 0 step_count, 1 up_factor, 2 down_factor, 3 prob_up, 4 discount_factor.
// The step count n is capped at 1024. A single shared 32x32 multiplier serves
// the ladder steps, the leaves and the interior nodes of the tree.
// One item is in work at a time; in_stall is high from acceptance until the
// result is handed to the output register, so a new item may enter while the
// last result waits.
// A stalled receiver holds the result in the output register; a finished item
// waits in the core until that register is free.
// Reset (rst, synchronous) clears the handshake state and loads the register
// defaults; the node and ladder memories need no clearing.
module american_put_binomial_pricer
  import apbp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DATA_W-1:0]    spot_price,
  input  logic [DATA_W-1:0]    strike_price,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_W-1:0]    option_value
);

  apbp_cfg_t         cfg;
  apbp_status_t      status;
  logic [DATA_W-1:0] result;
  logic              out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_count      <= RST_STEP_COUNT;
      cfg.up_factor       <= RST_UP_FACTOR;
      cfg.down_factor     <= RST_DOWN_FACT;
      cfg.prob_up         <= RST_PROB_UP;
      cfg.discount_factor <= RST_DISCOUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_COUNT: cfg.step_count      <= cfg_data[STEP_W-1:0];
        REG_UP_FACTOR:  cfg.up_factor       <= cfg_data;
        REG_DOWN_FACT:  cfg.down_factor     <= cfg_data;
        REG_PROB_UP:    cfg.prob_up         <= cfg_data;
        REG_DISCOUNT:   cfg.discount_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign in_stall = status.busy;

  apbp_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .start        (in_valid && !in_stall),
    .spot_price   (spot_price),
    .strike_price (strike_price),
    .out_free     (out_free),
    .status       (status),
    .result       (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status.done) begin
      out_valid    <= 1'b1;
      option_value <= result;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### hw/rtl/apbp_node_mem.sv
module apbp_node_mem
  import apbp_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [0:MAX_STEPS];

  // one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/apbp_ladder_mem.sv
module apbp_ladder_mem
  import apbp_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [LAD_W-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  output logic [LAD_W-1:0]  rdata_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [LAD_W-1:0]  rdata_b
);

  // each word holds {spot ladder, down ladder} for one index
  logic [LAD_W-1:0] mem [0:MAX_STEPS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hw/rtl/apbp_core.sv
module apbp_core
  import apbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  apbp_cfg_t         cfg,
  input  logic              start,
  input  logic [DATA_W-1:0] spot_price,
  input  logic [DATA_W-1:0] strike_price,
  input  logic              out_free,
  output apbp_status_t      status,
  output logic [DATA_W-1:0] result
);

  typedef enum logic [3:0] {
    S_IDLE, S_L_INIT, S_L_MU, S_L_MD, S_L_WR,
    S_F_RD, S_F_MUL, S_F_WR,
    S_R_RD0, S_R_RD1, S_R_A, S_R_B, S_R_C, S_R_D, S_R_E,
    S_DONE
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] n_steps;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] row;
  logic [DATA_W-1:0] spot;
  logic [DATA_W-1:0] strike;
  logic [DATA_W-1:0] cur_u;
  logic [DATA_W-1:0] cur_d;
  logic [DATA_W-1:0] lad_u;
  logic [DATA_W-1:0] lad_d;
  logic [DATA_W-1:0] vup;
  logic [DATA_W-1:0] vdown;
  logic [DATA_W-1:0] exer;
  logic [LAD_W-1:0]  prod;
  logic [LAD_W:0]    acc;

  logic [DATA_W-1:0] mul_a;
  logic [DATA_W-1:0] mul_b;
  logic [DATA_W-1:0] prod_sat;
  logic [LAD_W+1:0]  acc_next;
  logic [LAD_W:0]    hold_sum;
  logic [DATA_W-1:0] hold;
  logic [DATA_W-1:0] node_new;

  logic              node_we;
  logic [ADDR_W-1:0] node_waddr;
  logic [DATA_W-1:0] node_wdata;
  logic [ADDR_W-1:0] node_raddr;
  logic [DATA_W-1:0] node_rdata;
  logic              lad_we;
  logic [LAD_W-1:0]  lad_wdata;
  logic [ADDR_W-1:0] lad_raddr_a;
  logic [ADDR_W-1:0] lad_raddr_b;
  logic [LAD_W-1:0]  lad_rdata_a;
  logic [LAD_W-1:0]  lad_rdata_b;

  apbp_node_mem u_node_mem (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  apbp_ladder_mem u_ladder_mem (
    .clk     (clk),
    .we      (lad_we),
    .waddr   (idx),
    .wdata   (lad_wdata),
    .raddr_a (lad_raddr_a),
    .rdata_a (lad_rdata_a),
    .raddr_b (lad_raddr_b),
    .rdata_b (lad_rdata_b)
  );

  // step count saturated to the tree size
  assign n_steps = (cfg.step_count > STEP_W'(MAX_STEPS)) ? ADDR_W'(MAX_STEPS)
                                                         : cfg.step_count[ADDR_W-1:0];

  // shared multiplier operand select
  always_comb begin
    mul_a = cur_u;
    mul_b = cfg.up_factor;
    case (state)
      S_L_MU:  begin mul_a = cur_u;              mul_b = cfg.up_factor;   end
      S_L_MD:  begin mul_a = cur_d;              mul_b = cfg.down_factor; end
      S_F_MUL: begin mul_a = lad_rdata_a[LAD_W-1:DATA_W];
                     mul_b = lad_rdata_b[DATA_W-1:0];                     end
      S_R_A:   begin mul_a = cfg.prob_up;        mul_b = node_rdata;      end
      S_R_B:   begin mul_a = cfg.prob_up;        mul_b = vdown;           end
      S_R_C:   begin mul_a = lad_u;              mul_b = lad_d;           end
      S_R_D:   begin mul_a = cfg.discount_factor;
                     mul_b = acc[LAD_W-1:DATA_W];                         end
      default: begin mul_a = cur_u;              mul_b = cfg.up_factor;   end
    endcase
  end

  // rounding, expectation and node value
  assign prod_sat = q30_round_sat(prod);
  assign acc_next = {1'b0, acc} + {2'b00, vdown, {DATA_W{1'b0}}} - {2'b00, prod};
  assign hold_sum = {1'b0, prod} + 65'(64'd1 << 31);
  assign hold     = hold_sum[LAD_W-1:DATA_W];
  assign node_new = (exer > hold) ? exer : hold;

  // memory ports
  always_comb begin
    node_we     = 1'b0;
    node_waddr  = idx;
    node_wdata  = node_new;
    node_raddr  = idx + ADDR_W'(1);
    lad_we      = 1'b0;
    lad_wdata   = {cur_u, prod_sat};
    lad_raddr_a = idx;
    lad_raddr_b = row - idx;
    case (state)
      S_L_INIT: begin
        lad_we    = 1'b1;
        lad_wdata = {spot, Q30_ONE};
      end
      S_L_WR: lad_we = 1'b1;
      S_F_RD: lad_raddr_b = n_steps - idx;
      S_F_WR: begin
        node_we    = 1'b1;
        node_wdata = put_payoff(strike, prod_sat);
      end
      S_R_RD0: node_raddr = '0;
      S_R_E:   node_we = 1'b1;
      default: ;
    endcase
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      row   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            spot   <= spot_price;
            strike <= strike_price;
            state  <= S_L_INIT;
          end
        end
        S_L_INIT: begin
          cur_u <= spot;
          cur_d <= Q30_ONE;
          if (n_steps == '0) begin
            idx   <= '0;
            state <= S_F_RD;
          end else begin
            idx   <= ADDR_W'(1);
            state <= S_L_MU;
          end
        end
        S_L_MU: state <= S_L_MD;
        S_L_MD: begin
          cur_u <= prod_sat;
          state <= S_L_WR;
        end
        S_L_WR: begin
          cur_d <= prod_sat;
          if (idx == n_steps) begin
            idx   <= '0;
            state <= S_F_RD;
          end else begin
            idx   <= idx + ADDR_W'(1);
            state <= S_L_MU;
          end
        end
        S_F_RD:  state <= S_F_MUL;
        S_F_MUL: state <= S_F_WR;
        S_F_WR: begin
          if (idx == n_steps) begin
            idx <= '0;
            if (n_steps == '0) begin
              result <= put_payoff(strike, prod_sat);
              state  <= S_DONE;
            end else begin
              row   <= n_steps - ADDR_W'(1);
              state <= S_R_RD0;
            end
          end else begin
            idx   <= idx + ADDR_W'(1);
            state <= S_F_RD;
          end
        end
        S_R_RD0: state <= S_R_RD1;
        S_R_RD1: begin
          if (idx == '0) begin
            vdown <= node_rdata;
          end
          state <= S_R_A;
        end
        S_R_A: begin
          vup   <= node_rdata;
          lad_u <= lad_rdata_a[LAD_W-1:DATA_W];
          lad_d <= lad_rdata_b[DATA_W-1:0];
          state <= S_R_B;
        end
        S_R_B: begin
          acc   <= {1'b0, prod} + 65'(64'd1 << 31);
          state <= S_R_C;
        end
        S_R_C: begin
          acc   <= acc_next[LAD_W:0];
          state <= S_R_D;
        end
        S_R_D: begin
          exer  <= put_payoff(strike, prod_sat);
          state <= S_R_E;
        end
        S_R_E: begin
          vdown <= vup;
          if (idx == row) begin
            idx <= '0;
            if (row == '0) begin
              result <= node_new;
              state  <= S_DONE;
            end else begin
              row   <= row - ADDR_W'(1);
              state <= S_R_RD0;
            end
          end else begin
            idx   <= idx + ADDR_W'(1);
            state <= S_R_RD1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status.busy = (state != S_IDLE);
  assign status.done = (state == S_DONE) && out_free;

endmodule

### hw/rtl/apbp_checker.sv
module apbp_checker
  import apbp_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DATA_W-1:0] option_value
);

  // result stays offered while stalled
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

  // stalled result does not change
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(option_value))
    else $error("result changed under stall");

  // one item at a time: block is busy right after an item is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // no result can appear the cycle after an item is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too early");

  // reset empties the output
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind american_put_binomial_pricer apbp_checker u_apbp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .option_value (option_value)
);

### tb/sv/american_put_binomial_pricer_test.sv
import apbp_pkg::*;

// put price book: holds the tree settings and the queue of awaited root values
class put_price_book;
  bit [10:0] steps;
  bit [31:0] up_mul;
  bit [31:0] down_mul;
  bit [31:0] p_up;
  bit [31:0] disc;
  bit [31:0] pending_values[$];
  int        mismatches;

  function new();
    steps    = RST_STEP_COUNT;
    up_mul   = RST_UP_FACTOR;
    down_mul = RST_DOWN_FACT;
    p_up     = RST_PROB_UP;
    disc     = RST_DISCOUNT;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] data);
    case (idx)
      REG_STEP_COUNT: steps = data[10:0];
      REG_UP_FACTOR:  up_mul = data;
      REG_DOWN_FACT:  down_mul = data;
      REG_PROB_UP:    p_up = data;
      REG_DISCOUNT:   disc = data;
      default: ;
    endcase
  endfunction

  // Q2.30 product, round half up, saturate
  function bit [31:0] q30_mul(bit [31:0] a, bit [31:0] b);
    bit [63:0] prod;
    prod = {32'd0, a} * {32'd0, b} + 64'd536870912;
    prod = prod >> 30;
    return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
  endfunction

  function bit [31:0] exercise(bit [31:0] strike, bit [31:0] price);
    return (strike > price) ? strike - price : 32'd0;
  endfunction

  // roll the tree back to its root
  function bit [31:0] root_value(bit [31:0] spot, bit [31:0] strike);
    bit [31:0] spot_lad[];
    bit [31:0] down_lad[];
    bit [31:0] node[];
    bit [63:0] pu, pd, sum, hold;
    bit [31:0] ex;
    int n;
    n = (steps > MAX_STEPS) ? MAX_STEPS : steps;
    spot_lad = new[n + 1];
    down_lad = new[n + 1];
    node = new[n + 1];
    pu = {32'd0, p_up};
    pd = 64'h1_0000_0000 - pu;
    spot_lad[0] = spot;
    down_lad[0] = Q30_ONE;
    for (int j = 1; j <= n; j++) begin
      spot_lad[j] = q30_mul(spot_lad[j-1], up_mul);
      down_lad[j] = q30_mul(down_lad[j-1], down_mul);
    end
    for (int j = 0; j <= n; j++)
      node[j] = exercise(strike, q30_mul(spot_lad[j], down_lad[n-j]));
    for (int row = n - 1; row >= 0; row--) begin
      for (int j = 0; j <= row; j++) begin
        sum  = pu * {32'd0, node[j+1]} + pd * {32'd0, node[j]} + 64'h8000_0000;
        sum  = sum >> 32;
        hold = ({32'd0, disc} * sum + 64'h8000_0000) >> 32;
        ex   = exercise(strike, q30_mul(spot_lad[j], down_lad[row-j]));
        node[j] = ({32'd0, ex} > hold) ? ex : hold[31:0];
      end
    end
    return node[0];
  endfunction

  function void note_item(bit [31:0] spot, bit [31:0] strike);
    pending_values.push_back(root_value(spot, strike));
  endfunction

  function void check_value(bit [31:0] got);
    bit [31:0] want;
    if (pending_values.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected option_value %h", got);
      return;
    end
    want = pending_values.pop_front();
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) $display("option_value mismatch: expected %h, got %h", want, got);
    end
  endfunction
endclass

module american_put_binomial_pricer_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [DATA_W-1:0]    spot_price = '0;
  logic [DATA_W-1:0]    strike_price = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DATA_W-1:0]    option_value;

  put_price_book book = new();
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  american_put_binomial_pricer dut (.*);

  always #2 clk = ~clk;

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // result check
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) book.check_value(option_value);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    book.set_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_tree(bit [31:0] n, bit [31:0] u, bit [31:0] d, bit [31:0] p,
                          bit [31:0] df);
    write_reg(REG_STEP_COUNT, n);
    write_reg(REG_UP_FACTOR, u);
    write_reg(REG_DOWN_FACT, d);
    write_reg(REG_PROB_UP, p);
    write_reg(REG_DISCOUNT, df);
  endtask

  task automatic send_item(bit [31:0] spot, bit [31:0] strike);
    @(negedge clk);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    spot_price <= spot;
    strike_price <= strike;
    do @(posedge clk); while (in_stall);
    book.note_item(spot, strike);
  endtask

  task automatic end_items();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // wait until every root value is back, then let the block settle
  task automatic drain();
    end_items();
    while (book.pending_values.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic bit [31:0] pick(bit [31:0] typical);
    return ($urandom_range(7) == 0) ? $urandom : typical;
  endfunction

  task automatic random_item();
    bit [31:0] s, k;
    if ($urandom_range(3) == 0) begin
      s = $urandom;
      k = $urandom;
    end else begin
      s = $urandom_range(32'h0100_0000, 32'h0001_0000);
      k = s + $urandom_range(s >> 2) - (s >> 3);
    end
    send_item(s, k);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero steps: root is the leaf payoff
    set_tree(0, RST_UP_FACTOR, RST_DOWN_FACT, RST_PROB_UP, RST_DISCOUNT);
    send_item(32'h0, 32'h0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'h0, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'h0);
    send_item(32'h0064_0000, 32'h0078_0000);
    drain();

    // saturating prices, zero down factor, probability and discount
    set_tree(3, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    send_item(32'hFFFF_0000, 32'hFFFF_FFFF);
    send_item(32'h0001_0000, 32'h0002_0000);
    send_item(32'hFFFF_FFFF, 32'h8000_0000);
    drain();

    // full probability, zero up factor
    set_tree(5, 32'h0, 32'h3F00_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'h0064_0000, 32'h0064_0000);
    send_item(32'h0050_0000, 32'h0064_0000);
    drain();

    // typical tree, one step
    set_tree(1, 32'h4200_0000, 32'h3E00_0000, 32'h8000_0000, 32'hFFF0_0000);
    send_item(32'h0064_0000, 32'h0064_0000);
    send_item(32'h0064_0000, 32'h0096_0000);
    drain();

    // step count above the maximum: saturates to the largest tree
    set_tree(2047, 32'h4010_0000, 32'h3FF0_0000, 32'h8000_0000, 32'hFFFF_F000);
    send_item(32'h0064_0000, 32'h0064_0000);
    drain();

    // random trees under each idling pattern
    for (int ph = 0; ph < 8; ph++) begin
      set_tree($urandom_range(14),
               pick(32'h4000_0000 + $urandom_range(32'h0400_0000)),
               pick(32'h4000_0000 - $urandom_range(32'h0400_0000)),
               pick($urandom_range(32'hC000_0000, 32'h4000_0000)),
               pick(32'hFFFF_FFFF - $urandom_range(32'h0100_0000)));
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 67; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 67; end
        default: begin gap_pct = 6; stall_pct = 6; end
      endcase
      // long receiver hold-off so the input backs up
      if (ph == 4) hold_cycles = 3000;
      for (int i = 0; i < 11; i++) random_item();
      drain();
    end

    if (book.mismatches == 0) begin
      $display("[american_put_binomial_pricer] OK");
    end else begin
      $display("[american_put_binomial_pricer] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("[american_put_binomial_pricer] ERROR");
    $finish;
  end
endmodule
